// File: rtl/core/coct_pkg.sv
`default_nettype none

package coct_pkg;

   localparam int ENTITY_COUNT_DEF = 128;
   localparam int GRID_WIDTH_DEF   = 32;
   localparam int GRID_HEIGHT_DEF  = 32;

   localparam int CMD_W    = 2;
   localparam int ID_W     = 7;
   localparam int COORD_W  = 5;
   localparam int STATUS_W = 2;
   localparam int LINK_W   = 8;

   localparam logic [LINK_W-1:0] LINK_NONE = 8'hFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD     = 2'd0,
      CMD_MOVE    = 2'd1,
      CMD_REMOVE  = 2'd2,
      CMD_COMPARE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_PLACED   = 2'd1,
      ST_UNPLACED = 2'd2,
      ST_MISSING  = 2'd3
   } status_type;

   // address width for a table of n entries, never below one bit
   function automatic int addr_w(input int n);
      int w;
      w = $clog2(n);
      return (w < 1) ? 1 : w;
   endfunction

   // entity word: {next, y, x, placed}
   function automatic int ent_w(input int gw, input int gh);
      return LINK_W + addr_w(gh) + addr_w(gw) + 1;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/coct_ifs.sv
`default_nettype none

interface coct_req_if;
   logic                         valid;
   logic                         ready;
   logic [coct_pkg::CMD_W-1:0]   command;
   logic [coct_pkg::ID_W-1:0]    entity;
   logic [coct_pkg::ID_W-1:0]    other_entity;
   logic [coct_pkg::COORD_W-1:0] cell_x;
   logic [coct_pkg::COORD_W-1:0] cell_y;

   modport source (output valid, command, entity, other_entity, cell_x, cell_y,
                   input ready);
   modport sink   (input valid, command, entity, other_entity, cell_x, cell_y,
                   output ready);
endinterface

interface coct_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [coct_pkg::STATUS_W-1:0] status;
   logic                          same_cell;

   modport source (output valid, status, same_cell, input ready);
   modport sink   (input valid, status, same_cell, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cell_occupancy_chain_table.sv
// Occupancy chains for a 2D grid: one chain of entities per cell.
// req_chan carries one command word (add, move, remove, compare); rsp_chan
// returns one word per command with a status and the same-cell flag.
// Both channels move a word when valid and ready are high at a clock edge.
// After reset the block sweeps the head table and the entity table, one
// entry a cycle, over max(GRID_WIDTH*GRID_HEIGHT, ENTITY_COUNT) entries
// (1024 at the defaults); req_chan.ready stays low during the sweep.
// One command is in flight at a time. Add passes through S_ENT, S_LINK
// and S_DONE, compare through S_ENT, S_OTHER and S_DONE; a command turned
// away at the entity lookup goes from S_ENT straight to S_DONE. Move and
// remove walk the old cell's chain through the entity memory: S_HEAD,
// then S_CHK and S_STEP for each link, then S_UNLINKED, and S_LINK for move.
// The entity memory has a single read port, so each link takes its own read.
// The answer sits in an output register; the next command is accepted
// while it waits. If the receiver stalls, the following answer waits in the
// sequencer until the output register frees, and input is held off.
`default_nettype none

module cell_occupancy_chain_table #(
   parameter int ENTITY_COUNT = coct_pkg::ENTITY_COUNT_DEF,
   parameter int GRID_WIDTH   = coct_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT  = coct_pkg::GRID_HEIGHT_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   coct_req_if.sink   req_chan,
   coct_rsp_if.source rsp_chan
);
   import coct_pkg::*;

   localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
   localparam int CELL_W = addr_w(CELLS);
   localparam int ENT_W  = addr_w(ENTITY_COUNT);
   localparam int EW     = ent_w(GRID_WIDTH, GRID_HEIGHT);

   localparam logic [LINK_W-1:0] ENT_LIMIT = LINK_W'(ENTITY_COUNT);

   logic                head_we;
   logic [CELL_W-1:0]   head_waddr;
   logic [LINK_W-1:0]   head_wdata;
   logic [CELL_W-1:0]   head_raddr;
   logic [LINK_W-1:0]   head_rdata;
   logic                ent_we;
   logic [ENT_W-1:0]    ent_waddr;
   logic [EW-1:0]       ent_wdata;
   logic [ENT_W-1:0]    ent_raddr;
   logic [EW-1:0]       ent_rdata;

   coct_ram #(.WIDTH(LINK_W), .DEPTH(CELLS)) u_head_ram (
      .clock (clock),
      .we    (head_we),
      .waddr (head_waddr),
      .wdata (head_wdata),
      .raddr (head_raddr),
      .rdata (head_rdata)
   );

   coct_ram #(.WIDTH(EW), .DEPTH(ENTITY_COUNT)) u_ent_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   coct_ctrl #(
      .ENTITY_COUNT (ENTITY_COUNT),
      .GRID_WIDTH   (GRID_WIDTH),
      .GRID_HEIGHT  (GRID_HEIGHT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .head_we    (head_we),
      .head_waddr (head_waddr),
      .head_wdata (head_wdata),
      .head_raddr (head_raddr),
      .head_rdata (head_rdata),
      .ent_we     (ent_we),
      .ent_waddr  (ent_waddr),
      .ent_wdata  (ent_wdata),
      .ent_raddr  (ent_raddr),
      .ent_rdata  (ent_rdata)
   );

   // a chain head is always empty or a real entity
   a_head_link: assert property (@(posedge clock) disable iff (reset)
      head_we |-> (head_wdata == LINK_NONE || head_wdata < ENT_LIMIT))
      else $error("head table written with a bad link");

   // a next link is always end of chain or a real entity
   a_next_link: assert property (@(posedge clock) disable iff (reset)
      ent_we |-> (ent_wdata[EW-1 -: LINK_W] == LINK_NONE ||
                  ent_wdata[EW-1 -: LINK_W] < ENT_LIMIT))
      else $error("entity table written with a bad next link");

   // no command is taken once reset has been seen, as the clearing sweep starts
   a_clear_hold: assert property (@(posedge clock)
      reset |=> !req_chan.ready)
      else $error("input accepted during the clearing sweep");

   // an answer never appears on the cycle right after a command is taken
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !$rose(rsp_chan.valid))
      else $error("answer produced too early");

endmodule

`default_nettype wire

// File: rtl/core/coct_ram.sv
`default_nettype none

module coct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int AW   = coct_pkg::addr_w(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   import coct_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// File: rtl/core/coct_ctrl.sv
`default_nettype none

module coct_ctrl #(
   parameter int ENTITY_COUNT = coct_pkg::ENTITY_COUNT_DEF,
   parameter int GRID_WIDTH   = coct_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT  = coct_pkg::GRID_HEIGHT_DEF,
   localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT,
   localparam int CELL_W      = coct_pkg::addr_w(CELLS),
   localparam int ENT_W       = coct_pkg::addr_w(ENTITY_COUNT),
   localparam int EW          = coct_pkg::ent_w(GRID_WIDTH, GRID_HEIGHT)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   coct_req_if.sink                          req_chan,
   coct_rsp_if.source                        rsp_chan,
   output logic                              head_we,
   output logic [CELL_W-1:0]                 head_waddr,
   output logic [coct_pkg::LINK_W-1:0]       head_wdata,
   output logic [CELL_W-1:0]                 head_raddr,
   input  wire logic [coct_pkg::LINK_W-1:0]  head_rdata,
   output logic                              ent_we,
   output logic [ENT_W-1:0]                  ent_waddr,
   output logic [EW-1:0]                     ent_wdata,
   output logic [ENT_W-1:0]                  ent_raddr,
   input  wire logic [EW-1:0]                ent_rdata
);
   import coct_pkg::*;

   localparam int XW     = addr_w(GRID_WIDTH);
   localparam int YW     = addr_w(GRID_HEIGHT);
   localparam int X_LO   = 1;
   localparam int Y_LO   = 1 + XW;
   localparam int N_LO   = 1 + XW + YW;
   localparam int CLR_N  = (CELLS > ENTITY_COUNT) ? CELLS : ENTITY_COUNT;
   localparam int CLR_W  = addr_w(CLR_N);
   localparam int STEP_W = $clog2(ENTITY_COUNT + 1);
   localparam int SAT_W  = COORD_W + 4;

   localparam logic [LINK_W-1:0] ENT_LIMIT = LINK_W'(ENTITY_COUNT);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ENT, S_OTHER, S_HEAD, S_CHK, S_STEP,
      S_UNLINKED, S_LINK, S_DONE
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [ID_W-1:0]     e_ff, e_in;
   logic [ID_W-1:0]     o_ff, o_in;
   logic [XW-1:0]       xn_ff, xn_in;
   logic [YW-1:0]       yn_ff, yn_in;
   logic [EW-1:0]       eword_ff, eword_in;
   logic [EW-1:0]       pword_ff, pword_in;
   logic [CELL_W-1:0]   cell_ff, cell_in;
   logic [LINK_W-1:0]   cur_ff, cur_in;
   logic [LINK_W-1:0]   prev_ff, prev_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic [CLR_W-1:0]    clr_ff, clr_in;
   status_type          status_ff, status_in;
   logic                same_ff, same_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_same_ff, rsp_same_in;

   logic                e_ok, o_ok, r_placed, e_placed;
   logic [XW-1:0]       r_x;
   logic [YW-1:0]       r_y;
   logic [LINK_W-1:0]   r_next, e_next;
   logic [SAT_W-1:0]    x_ext, y_ext, x_sat, y_sat;

   function automatic logic [CELL_W-1:0] cell_idx(input logic [XW-1:0] x,
                                                  input logic [YW-1:0] y);
      return CELL_W'(32'(x) * GRID_HEIGHT + 32'(y));
   endfunction

   assign e_ok     = {1'b0, e_ff} < ENT_LIMIT;
   assign o_ok     = {1'b0, o_ff} < ENT_LIMIT;
   assign r_placed = ent_rdata[0];
   assign r_x      = ent_rdata[X_LO +: XW];
   assign r_y      = ent_rdata[Y_LO +: YW];
   assign r_next   = ent_rdata[N_LO +: LINK_W];
   assign e_next   = eword_ff[N_LO +: LINK_W];
   assign e_placed = e_ok && r_placed;

   // saturate target cell to the grid
   assign x_ext = SAT_W'(req_chan.cell_x);
   assign y_ext = SAT_W'(req_chan.cell_y);
   assign x_sat = (x_ext >= SAT_W'(GRID_WIDTH)) ? SAT_W'(GRID_WIDTH - 1) : x_ext;
   assign y_sat = (y_ext >= SAT_W'(GRID_HEIGHT)) ? SAT_W'(GRID_HEIGHT - 1) : y_ext;

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.same_cell = rsp_same_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      e_in          = e_ff;
      o_in          = o_ff;
      xn_in         = xn_ff;
      yn_in         = yn_ff;
      eword_in      = eword_ff;
      pword_in      = pword_ff;
      cell_in       = cell_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      clr_in        = clr_ff;
      status_in     = status_ff;
      same_in       = same_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_same_in   = rsp_same_ff;

      head_we    = 1'b0;
      head_waddr = cell_ff;
      head_wdata = LINK_NONE;
      head_raddr = cell_ff;
      ent_we     = 1'b0;
      ent_waddr  = ENT_W'(e_ff);
      ent_wdata  = eword_ff;
      ent_raddr  = ENT_W'(cur_ff);

      case (state_ff)
         S_CLEAR: begin
            head_we    = 32'(clr_ff) < CELLS;
            head_waddr = CELL_W'(clr_ff);
            ent_we     = 32'(clr_ff) < ENTITY_COUNT;
            ent_waddr  = ENT_W'(clr_ff);
            ent_wdata  = {LINK_NONE, (EW - LINK_W)'(0)};
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + CLR_W'(1);
            end
         end
         S_IDLE: begin
            ent_raddr = ENT_W'(req_chan.entity);
            if (req_chan.valid) begin
               cmd_in    = cmd_type'(req_chan.command);
               e_in      = req_chan.entity;
               o_in      = req_chan.other_entity;
               xn_in     = x_sat[XW-1:0];
               yn_in     = y_sat[YW-1:0];
               same_in   = 1'b0;
               status_in = ST_OK;
               state_in  = S_ENT;
            end
         end
         S_ENT: begin
            eword_in = ent_rdata;
            case (cmd_ff)
               CMD_ADD: begin
                  if (!e_ok) begin
                     status_in = ST_UNPLACED;
                     state_in  = S_DONE;
                  end else if (r_placed) begin
                     status_in = ST_PLACED;
                     state_in  = S_DONE;
                  end else begin
                     cell_in    = cell_idx(xn_ff, yn_ff);
                     head_raddr = cell_idx(xn_ff, yn_ff);
                     state_in   = S_LINK;
                  end
               end
               CMD_MOVE, CMD_REMOVE: begin
                  if (!e_placed) begin
                     status_in = (cmd_ff == CMD_MOVE) ? ST_UNPLACED : ST_OK;
                     state_in  = S_DONE;
                  end else begin
                     cell_in    = cell_idx(r_x, r_y);
                     head_raddr = cell_idx(r_x, r_y);
                     prev_in    = LINK_NONE;
                     steps_in   = '0;
                     state_in   = S_HEAD;
                  end
               end
               default: begin
                  if (!e_placed || !o_ok) begin
                     status_in = ST_UNPLACED;
                     state_in  = S_DONE;
                  end else begin
                     ent_raddr = ENT_W'(o_ff);
                     state_in  = S_OTHER;
                  end
               end
            endcase
         end
         S_OTHER: begin
            if (!r_placed) begin
               status_in = ST_UNPLACED;
            end else begin
               same_in = (r_x == eword_ff[X_LO +: XW]) && (r_y == eword_ff[Y_LO +: YW]);
            end
            state_in = S_DONE;
         end
         S_HEAD: begin
            cur_in   = head_rdata;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (steps_ff == STEP_W'(ENTITY_COUNT) || cur_ff >= ENT_LIMIT) begin
               status_in = ST_MISSING;
               state_in  = S_DONE;
            end else if (cur_ff == {1'b0, e_ff}) begin
               if (prev_ff == LINK_NONE) begin
                  head_we    = 1'b1;
                  head_wdata = e_next;
               end else begin
                  ent_we    = 1'b1;
                  ent_waddr = ENT_W'(prev_ff);
                  ent_wdata = {e_next, pword_ff[N_LO-1:0]};
               end
               state_in = S_UNLINKED;
            end else begin
               ent_raddr = ENT_W'(cur_ff);
               state_in  = S_STEP;
            end
         end
         S_STEP: begin
            prev_in  = cur_ff;
            pword_in = ent_rdata;
            cur_in   = r_next;
            steps_in = steps_ff + STEP_W'(1);
            state_in = S_CHK;
         end
         S_UNLINKED: begin
            if (cmd_ff == CMD_REMOVE) begin
               ent_we    = 1'b1;
               ent_wdata = {eword_ff[EW-1:1], 1'b0};
               state_in  = S_DONE;
            end else begin
               cell_in    = cell_idx(xn_ff, yn_ff);
               head_raddr = cell_idx(xn_ff, yn_ff);
               state_in   = S_LINK;
            end
         end
         S_LINK: begin
            ent_we     = 1'b1;
            ent_wdata  = {head_rdata, yn_ff, xn_ff, 1'b1};
            head_we    = 1'b1;
            head_wdata = {1'b0, e_ff};
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_same_in   = same_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      e_ff          <= e_in;
      o_ff          <= o_in;
      xn_ff         <= xn_in;
      yn_ff         <= yn_in;
      eword_ff      <= eword_in;
      pword_ff      <= pword_in;
      cell_ff       <= cell_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      status_ff     <= status_in;
      same_ff       <= same_in;
      rsp_status_ff <= rsp_status_in;
      rsp_same_ff   <= rsp_same_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import coct_pkg::*;

   localparam int ENTITIES   = ENTITY_COUNT_DEF;
   localparam int COLUMNS    = GRID_WIDTH_DEF;
   localparam int ROWS       = GRID_HEIGHT_DEF;
   localparam int CELLS      = COLUMNS * ROWS;
   localparam int DRAIN_WAIT = 2 * ENTITIES + 40;

   typedef struct {
      status_type status;
      logic       same_cell;
   } answer_type;

   logic clock = 1'b0;
   logic reset;

   coct_req_if req_bus ();
   coct_rsp_if rsp_bus ();

   cell_occupancy_chain_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // grid model
   logic [LINK_W-1:0]  chain_head [CELLS];
   logic [LINK_W-1:0]  chain_next [ENTITIES];
   logic [COORD_W-1:0] spot_x     [ENTITIES];
   logic [COORD_W-1:0] spot_y     [ENTITIES];
   bit                 on_grid    [ENTITIES];

   answer_type pending_answers[$];
   int         mismatch_count = 0;
   bit         idle_on = 1'b1;

   task automatic clear_grid_model();
      foreach (chain_head[i]) chain_head[i] = LINK_NONE;
      foreach (chain_next[i]) begin
         chain_next[i] = LINK_NONE;
         spot_x[i]     = '0;
         spot_y[i]     = '0;
         on_grid[i]    = 1'b0;
      end
   endtask

   function automatic int cell_index(input int ent);
      return int'(spot_x[ent]) * ROWS + int'(spot_y[ent]);
   endfunction

   function automatic void attach(input int ent, input int x, input int y);
      int c;
      spot_x[ent] = (x >= COLUMNS) ? COORD_W'(COLUMNS - 1) : COORD_W'(x);
      spot_y[ent] = (y >= ROWS) ? COORD_W'(ROWS - 1) : COORD_W'(y);
      c = cell_index(ent);
      chain_next[ent] = chain_head[c];
      chain_head[c]   = LINK_W'(ent);
   endfunction

   function automatic bit detach(input int ent);
      int c;
      int cur;
      int prev;
      c    = cell_index(ent);
      cur  = int'(chain_head[c]);
      prev = int'(LINK_NONE);
      for (int steps = 0; steps < ENTITIES; steps++) begin
         if (cur >= ENTITIES) return 1'b0;
         if (cur == ent) begin
            if (prev == int'(LINK_NONE)) chain_head[c] = chain_next[cur];
            else chain_next[prev] = chain_next[cur];
            return 1'b1;
         end
         prev = cur;
         cur  = int'(chain_next[cur]);
      end
      return 1'b0;
   endfunction

   function automatic answer_type apply_grid_command(input cmd_type cmd, input int ent,
                                                      input int oth, input int x,
                                                      input int y);
      answer_type a;
      bit         ent_live;
      a.status    = ST_OK;
      a.same_cell = 1'b0;
      ent_live    = (ent < ENTITIES) && on_grid[ent];
      case (cmd)
         CMD_ADD: begin
            if (ent >= ENTITIES) a.status = ST_UNPLACED;
            else if (ent_live) a.status = ST_PLACED;
            else begin
               attach(ent, x, y);
               on_grid[ent] = 1'b1;
            end
         end
         CMD_MOVE: begin
            if (!ent_live) a.status = ST_UNPLACED;
            else if (!detach(ent)) a.status = ST_MISSING;
            else attach(ent, x, y);
         end
         CMD_REMOVE: begin
            if (ent_live) begin
               if (detach(ent)) on_grid[ent] = 1'b0;
               else a.status = ST_MISSING;
            end
         end
         default: begin
            if (!ent_live || oth >= ENTITIES || !on_grid[oth]) a.status = ST_UNPLACED;
            else if (spot_x[ent] == spot_x[oth] && spot_y[ent] == spot_y[oth])
               a.same_cell = 1'b1;
         end
      endcase
      return a;
   endfunction

   task automatic send_command(input cmd_type cmd, input logic [ID_W-1:0] ent,
                               input logic [ID_W-1:0] oth,
                               input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.entity       <= ent;
      req_bus.other_entity <= oth;
      req_bus.cell_x       <= x;
      req_bus.cell_y       <= y;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_answers.push_back(apply_grid_command(cmd, int'(ent), int'(oth),
                                                   int'(x), int'(y)));
   endtask

   task automatic settle_answers();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // response sink with random stall bursts while idle_on is set
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : answer_check
      answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: status %0d same_cell %0d",
                        rsp_bus.status, rsp_bus.same_cell);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.same_cell !== want.same_cell) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status %0d same %0d, got status %0d same %0d",
                           want.status, want.same_cell, rsp_bus.status, rsp_bus.same_cell);
            end
         end
      end
   end

   task automatic test_placement_edges();
      send_command(CMD_ADD, 7'd0, 7'd127, 5'd0, 5'd0);
      send_command(CMD_ADD, 7'd127, 7'd0, 5'd31, 5'd31);
      send_command(CMD_ADD, 7'd0, 7'd0, 5'd17, 5'd3);
      send_command(CMD_ADD, 7'd5, 7'd127, 5'd31, 5'd0);
      send_command(CMD_ADD, 7'd6, 7'd0, 5'd0, 5'd31);
      settle_answers();
   endtask

   task automatic test_unplaced_commands();
      send_command(CMD_MOVE, 7'd9, 7'd0, 5'd1, 5'd1);
      send_command(CMD_REMOVE, 7'd9, 7'd0, 5'd0, 5'd0);
      send_command(CMD_COMPARE, 7'd9, 7'd0, 5'd0, 5'd0);
      send_command(CMD_COMPARE, 7'd0, 7'd9, 5'd0, 5'd0);
      settle_answers();
   endtask

   task automatic test_chain_walk();
      send_command(CMD_ADD, 7'd10, 7'd0, 5'd7, 5'd7);
      send_command(CMD_ADD, 7'd11, 7'd0, 5'd7, 5'd7);
      send_command(CMD_ADD, 7'd12, 7'd0, 5'd7, 5'd7);
      send_command(CMD_COMPARE, 7'd10, 7'd12, 5'd0, 5'd0);
      send_command(CMD_COMPARE, 7'd10, 7'd127, 5'd0, 5'd0);
      send_command(CMD_COMPARE, 7'd0, 7'd0, 5'd0, 5'd0);
      send_command(CMD_MOVE, 7'd11, 7'd0, 5'd31, 5'd31);
      send_command(CMD_REMOVE, 7'd10, 7'd0, 5'd0, 5'd0);
      send_command(CMD_REMOVE, 7'd12, 7'd0, 5'd0, 5'd0);
      send_command(CMD_MOVE, 7'd127, 7'd0, 5'd7, 5'd7);
      send_command(CMD_COMPARE, 7'd11, 7'd127, 5'd0, 5'd0);
      settle_answers();
   endtask

   task automatic test_random_traffic(input int count);
      logic [COORD_W-1:0] hot_x [4];
      logic [COORD_W-1:0] hot_y [4];
      logic [ID_W-1:0]    ent;
      logic [ID_W-1:0]    oth;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      cmd_type            cmd;
      int                 pick;
      int                 k;
      foreach (hot_x[i]) begin
         hot_x[i] = COORD_W'($urandom);
         hot_y[i] = COORD_W'($urandom);
      end
      for (int n = 0; n < count; n++) begin
         ent  = ID_W'($urandom);
         oth  = ID_W'($urandom);
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 2) != 0) begin
            k = $urandom_range(0, 3);
            x = hot_x[k];
            y = hot_y[k];
         end else begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
         end
         // unplaced: mostly add; placed: mostly move, remove, compare
         if (!on_grid[ent])
            cmd = (pick < 75) ? CMD_ADD : (pick < 85) ? CMD_MOVE :
                  (pick < 93) ? CMD_REMOVE : CMD_COMPARE;
         else
            cmd = (pick < 40) ? CMD_MOVE : (pick < 60) ? CMD_REMOVE :
                  (pick < 90) ? CMD_COMPARE : CMD_ADD;
         if (cmd == CMD_COMPARE)
            for (int t = 0; t < 8 && !on_grid[oth]; t++) oth = ID_W'($urandom);
         send_command(cmd, ent, oth, x, y);
      end
   endtask

   task automatic test_full_rate(input int count);
      idle_on = 1'b0;
      test_random_traffic(count);
   endtask

   initial begin
      clear_grid_model();
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_ADD;
      req_bus.entity       <= '0;
      req_bus.other_entity <= '0;
      req_bus.cell_x       <= '0;
      req_bus.cell_y       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_placement_edges();
      test_unplaced_commands();
      test_chain_walk();
      test_random_traffic(700);
      test_full_rate(130);

      settle_answers();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
rtl/core/coct_pkg.sv
rtl/core/coct_ifs.sv
rtl/core/coct_ram.sv
rtl/core/coct_ctrl.sv
rtl/core/cell_occupancy_chain_table.sv
bench/tb_top.sv
